>>> sv/assert_macros.svh
// Assertion macros used by the port checks in sv/pfa_checker.sv.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> sv/pfa_pkg.sv
// Shared types and constants of the partition fit allocator.
// No dependencies; used by pfa_cell, partition_fit_allocator and pfa_checker.
package pfa_pkg;

  localparam int unsigned PARTITIONS_DEF = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam logic [15:0] MIN_FRAG_RESET = 16'd5;

  // Configuration register indexes
  localparam logic CFG_ALLOC_POLICY = 1'b0;
  localparam logic CFG_MIN_FRAGMENT = 1'b1;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_e;

  typedef enum logic [0:0] {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STS_GRANTED = 2'd0,
    STS_NO_FIT  = 2'd1,
    STS_LOADED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [3:0]  entry_index;
    logic [31:0] entry_start;
    logic [31:0] entry_size;
    logic [31:0] request_size;
  } in_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] grant_address;
    logic [3:0]  grant_index;
  } out_rsp_t;

  // Best candidate seen so far as it travels along the cell row
  typedef struct packed {
    logic        found;
    logic [31:0] size;
    logic [31:0] start;
  } cand_t;

  // Broadcast write into one cell
  typedef struct packed {
    logic        en;
    logic        set_start;
    logic [31:0] start;
    logic [31:0] size;
    logic        usable;
  } wr_t;

endpackage

>>> sv/partition_fit_allocator.sv
// Partition fit allocator: a row of PARTITIONS slot cells holds free partitions.
// A load request writes one slot, then answers. An allocate request
// sends a candidate record down the cell row, one cell per cycle, and answers
// once it has passed accept, the scan along the whole row, commit and response.
// One request is in work at a time; a finished response waits in the output
// register while the next is accepted. The block carves the request from the top
// of the chosen partition and returns start plus remaining size. Depends on
// pfa_pkg and pfa_cell.
module partition_fit_allocator import pfa_pkg::*; #(
  parameter int unsigned PARTITIONS = PARTITIONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_rsp_t              out_data_o
);

  localparam int unsigned IdxW = $clog2(PARTITIONS);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q;
  logic [31:0]     req_q;
  logic [IdxW-1:0] base_q;
  logic [IdxW-1:0] roving_q;
  policy_e         policy_q;
  logic [15:0]     min_frag_q;
  status_e         res_status_q;
  logic [3:0]      res_idx_q;
  logic [31:0]     rem_q;
  logic [31:0]     start_q;
  logic            out_valid_q;
  out_rsp_t        out_data_q;

  logic            accept;
  logic            scan_done;
  logic            out_free;
  logic            load_ok;
  cand_t           sel;
  logic [IdxW-1:0] sel_idx;
  logic [31:0]     rem;
  wr_t             wr;
  logic [IdxW-1:0] wr_idx;

  cand_t           cand_c [PARTITIONS+1];
  logic [IdxW-1:0] cand_idx_c [PARTITIONS+1];
  cand_t           aux_c [PARTITIONS+1];
  logic [IdxW-1:0] aux_idx_c [PARTITIONS+1];

  assign accept    = in_valid_i && !in_stall_o;
  assign scan_done = (cnt_q == IdxW'(PARTITIONS - 1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_ok   = (32'(in_data_i.entry_index) < PARTITIONS);

  // Pick the forward candidate, else the wrapped one
  assign sel     = cand_c[PARTITIONS].found ? cand_c[PARTITIONS] : aux_c[PARTITIONS];
  assign sel_idx = cand_c[PARTITIONS].found ? cand_idx_c[PARTITIONS]
                                            : aux_idx_c[PARTITIONS];
  assign rem     = sel.size - req_q;

  // Cell row
  assign cand_c[0]     = '0;
  assign cand_idx_c[0] = '0;
  assign aux_c[0]      = '0;
  assign aux_idx_c[0]  = '0;

  for (genvar k = 0; k < PARTITIONS; k++) begin : g_cell
    pfa_cell #(
      .IdxW(IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IdxW'(k)),
      .req_size_i (req_q),
      .policy_i   (policy_q),
      .base_i     (base_q),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx),
      .cand_i     (cand_c[k]),
      .cand_idx_i (cand_idx_c[k]),
      .aux_i      (aux_c[k]),
      .aux_idx_i  (aux_idx_c[k]),
      .cand_o     (cand_c[k+1]),
      .cand_idx_o (cand_idx_c[k+1]),
      .aux_o      (aux_c[k+1]),
      .aux_idx_o  (aux_idx_c[k+1])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.req_type == REQ_ALLOC) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: input stall and slot writes
  always_comb begin
    in_stall_o = 1'b1;
    wr         = '0;
    wr_idx     = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept && in_data_i.req_type == REQ_LOAD) begin
          wr.en        = load_ok;
          wr.set_start = 1'b1;
          wr.start     = in_data_i.entry_start;
          wr.size      = in_data_i.entry_size;
          wr.usable    = (in_data_i.entry_size != '0);
          wr_idx       = IdxW'(in_data_i.entry_index);
        end
      end
      ST_COMMIT: begin
        wr.en     = sel.found;
        wr.size   = rem;
        wr.usable = !((rem == '0) || (rem < {16'h0, min_frag_q}));
        wr_idx    = sel_idx;
      end
      ST_SCAN, ST_RESP: begin
        in_stall_o = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      roving_q   <= '0;
      policy_q   <= POL_FIRST;
      min_frag_q <= MIN_FRAG_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == ST_COMMIT && sel.found && policy_q == POL_NEXT) begin
        roving_q <= sel_idx;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ALLOC_POLICY: policy_q   <= policy_e'(cfg_data_i[1:0]);
          CFG_MIN_FRAGMENT: min_frag_q <= cfg_data_i[15:0];
          default:          policy_q   <= policy_q;
        endcase
      end
    end
  end

  // Request and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q        <= in_data_i.request_size;
      base_q       <= (policy_q == POL_NEXT) ? roving_q : '0;
      res_status_q <= STS_LOADED;
      res_idx_q    <= '0;
      rem_q        <= '0;
      start_q      <= '0;
    end else if (state_q == ST_COMMIT) begin
      res_status_q <= sel.found ? STS_GRANTED : STS_NO_FIT;
      res_idx_q    <= sel.found ? 4'(sel_idx) : 4'h0;
      rem_q        <= sel.found ? rem : 32'h0;
      start_q      <= sel.found ? sel.start : 32'h0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      out_data_q.status        <= res_status_q;
      out_data_q.grant_address <= start_q + rem_q;
      out_data_q.grant_index   <= res_idx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/pfa_cell.sv
// One partition slot: start, size and usable bit, plus one stage of the search row.
// Depends on pfa_pkg.
module pfa_cell import pfa_pkg::*; #(
  parameter int unsigned IdxW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] idx_i,
  input  logic [31:0]     req_size_i,
  input  policy_e         policy_i,
  input  logic [IdxW-1:0] base_i,
  input  wr_t             wr_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  cand_t           cand_i,
  input  logic [IdxW-1:0] cand_idx_i,
  input  cand_t           aux_i,
  input  logic [IdxW-1:0] aux_idx_i,
  output cand_t           cand_o,
  output logic [IdxW-1:0] cand_idx_o,
  output cand_t           aux_o,
  output logic [IdxW-1:0] aux_idx_o
);

  logic [31:0]     size_q;
  logic [31:0]     start_q;
  logic            usable_q;
  logic            fits;
  logic            upper;
  logic            hit;
  cand_t           mine;
  cand_t           cand_d, aux_d;
  logic [IdxW-1:0] cand_idx_d, aux_idx_d;

  assign fits  = usable_q && (size_q >= req_size_i);
  assign upper = (idx_i >= base_i);
  assign hit   = wr_i.en && (wr_idx_i == idx_i);
  assign mine  = '{found: 1'b1, size: size_q, start: start_q};

  // Merge this slot into the travelling candidates
  always_comb begin
    cand_d     = cand_i;
    cand_idx_d = cand_idx_i;
    aux_d      = aux_i;
    aux_idx_d  = aux_idx_i;
    if (fits && upper) begin
      priority if (!cand_i.found) begin
        cand_d     = mine;
        cand_idx_d = idx_i;
      end else if (policy_i == POL_BEST && size_q < cand_i.size) begin
        cand_d     = mine;
        cand_idx_d = idx_i;
      end else if (policy_i == POL_WORST && size_q > cand_i.size) begin
        cand_d     = mine;
        cand_idx_d = idx_i;
      end else begin
        // Keep the earlier slot
        cand_d     = cand_i;
        cand_idx_d = cand_idx_i;
      end
    end
    // Slots below the roving pointer only serve as the wrapped choice
    if (fits && !upper && !aux_i.found) begin
      aux_d     = mine;
      aux_idx_d = idx_i;
    end
  end

  // Hand the candidates to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_o     <= '0;
      cand_idx_o <= '0;
      aux_o      <= '0;
      aux_idx_o  <= '0;
    end else begin
      cand_o     <= cand_d;
      cand_idx_o <= cand_idx_d;
      aux_o      <= aux_d;
      aux_idx_o  <= aux_idx_d;
    end
  end

  // Slot size and usable bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= '0;
      usable_q <= 1'b0;
    end else if (hit) begin
      size_q   <= wr_i.size;
      usable_q <= wr_i.usable;
    end
  end

  // Slot start, only written by a load
  always_ff @(posedge clk_i) begin
    if (hit && wr_i.set_start) begin
      start_q <= wr_i.start;
    end
  end

endmodule

>>> sv/pfa_checker.sv
// Port-level checks of the partition fit allocator, bound to the top level.
// Depends on pfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfa_port_checks import pfa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_data_o
);

  logic rsp_not_granted;
  logic rsp_fields_zero;

  assign rsp_not_granted = out_valid_o && (out_data_o.status != STS_GRANTED);
  assign rsp_fields_zero = (out_data_o.grant_address == '0) && (out_data_o.grant_index == '0);

  // Hold a stalled response
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Only a grant carries an address and slot
  `ASSERT_IMPLIES(a_nogrant_zero, rsp_not_granted, rsp_fields_zero)

  // One request at a time: busy right after an accept
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A new response appears only out of a busy cycle
  `ASSERT_IMPLIES(a_resp_from_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind partition_fit_allocator pfa_port_checks u_pfa_port_checks (.*);

>>> test/pfa_checker.sv
// Checker for the partition fit allocator: watches the config port and both channels,
// predicts each response from its own copy of the partition table and compares them.
// Depends on pfa_pkg.
module pfa_checker import pfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_req_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_rsp_t              out_data_i,
  output int                    mismatch_cnt_o,
  output int                    outstanding_o
);

  localparam int NPART = PARTITIONS_DEF;

  // Shadow partition table and configuration
  logic [31:0] size_q   [NPART];
  logic [31:0] start_q  [NPART];
  logic        usable_q [NPART];
  logic [3:0]  rover_q;
  policy_e     policy_q;
  logic [15:0] frag_floor_q;

  // Responses still owed by the block, oldest first
  out_rsp_t    grant_q [$];
  int          mism;

  // Apply one request to the shadow table and return the response it owes
  function automatic out_rsp_t fit_and_carve(input in_req_t r);
    out_rsp_t    rsp;
    int          pick;
    int          slot;
    logic [31:0] rem;
    rsp  = '0;
    pick = -1;
    if (r.req_type == REQ_LOAD) begin
      start_q[r.entry_index]  = r.entry_start;
      size_q[r.entry_index]   = r.entry_size;
      usable_q[r.entry_index] = (r.entry_size != '0);
      rsp.status = STS_LOADED;
      return rsp;
    end
    if (policy_q == POL_NEXT) begin
      // Search from the roving slot and wrap around the table
      for (int k = 0; k < NPART; k++) begin
        slot = (int'(rover_q) + k) % NPART;
        if (pick < 0 && usable_q[slot] && size_q[slot] >= r.request_size) pick = slot;
      end
    end else begin
      // First fit keeps the lowest index; ties keep the earlier slot
      for (int k = 0; k < NPART; k++) begin
        if (usable_q[k] && size_q[k] >= r.request_size) begin
          if (pick < 0) pick = k;
          else if (policy_q == POL_BEST && size_q[k] < size_q[pick]) pick = k;
          else if (policy_q == POL_WORST && size_q[k] > size_q[pick]) pick = k;
        end
      end
    end
    if (pick < 0) begin
      rsp.status = STS_NO_FIT;
      return rsp;
    end
    // Carve from the top end of the partition
    rem          = size_q[pick] - r.request_size;
    size_q[pick] = rem;
    if (rem == '0 || rem < {16'd0, frag_floor_q}) usable_q[pick] = 1'b0;
    if (policy_q == POL_NEXT) rover_q = 4'(pick);
    rsp.status        = STS_GRANTED;
    rsp.grant_address = start_q[pick] + rem;
    rsp.grant_index   = 4'(pick);
    return rsp;
  endfunction

  // Track config writes, check each accepted response, predict each accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NPART; i++) begin
        size_q[i]   = '0;
        start_q[i]  = '0;
        usable_q[i] = 1'b0;
      end
      rover_q        = '0;
      policy_q       = POL_FIRST;
      frag_floor_q   = MIN_FRAG_RESET;
      mism           = 0;
      grant_q.delete();
      mismatch_cnt_o <= 0;
      outstanding_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ALLOC_POLICY) policy_q = policy_e'(cfg_data_i[1:0]);
        else if (cfg_idx_i == CFG_MIN_FRAGMENT) frag_floor_q = cfg_data_i[15:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          mism++;
          $display("%0t: unexpected response: expected none, actual status %0d addr %h slot %0d",
                   $time, out_data_i.status, out_data_i.grant_address, out_data_i.grant_index);
        end else begin
          want = grant_q.pop_front();
          if (out_data_i.status !== want.status) begin
            mism++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_data_i.status);
          end
          if (out_data_i.grant_address !== want.grant_address) begin
            mism++;
            $display("%0t: grant_address mismatch: expected %h actual %h",
                     $time, want.grant_address, out_data_i.grant_address);
          end
          if (out_data_i.grant_index !== want.grant_index) begin
            mism++;
            $display("%0t: grant_index mismatch: expected %0d actual %0d",
                     $time, want.grant_index, out_data_i.grant_index);
          end
        end
      end
      if (in_valid_i && !in_stall_i) grant_q.push_back(fit_and_carve(in_data_i));
      mismatch_cnt_o <= mism;
      outstanding_o  <= grant_q.size();
    end
  end

endmodule

>>> test/partition_fit_allocator_tb.sv
// Testbench top for the partition fit allocator: drives config writes, directed and
// random requests with varied idling and back-pressure, and reports the verdict.
// Depends on pfa_pkg, partition_fit_allocator and pfa_checker.
module partition_fit_allocator_tb;
  import pfa_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 138;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic                  cfg_idx  = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_data;

  int                    mismatch_cnt;
  int                    outstanding;
  int                    send_idle_pct = 0;
  int                    stall_pct     = 0;
  int                    hold_left     = 0;
  bit                    hold_kick     = 1'b0;
  bit                    hold_seen     = 1'b0;
  int                    quiet_cycles  = 0;

  partition_fit_allocator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pfa_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: a long hold when kicked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Abort when no request or response has moved for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("partition_fit_allocator_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request after random idle cycles and hold it until accepted
  task automatic send(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_slot(input logic [3:0] idx, input logic [31:0] start,
                           input logic [31:0] size);
    in_req_t r;
    r             = '0;
    r.req_type    = REQ_LOAD;
    r.entry_index = idx;
    r.entry_start = start;
    r.entry_size  = size;
    send(r);
  endtask

  task automatic ask(input logic [31:0] amount);
    in_req_t r;
    r              = '0;
    r.req_type     = REQ_ALLOC;
    r.request_size = amount;
    send(r);
  endtask

  // Stop offering and wait until every owed response has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic program_regs(input policy_e pol, input logic [15:0] frag_floor);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ALLOC_POLICY;
    cfg_data <= CFG_DATA_W'(pol);
    @(posedge clk);
    cfg_idx  <= CFG_MIN_FRAGMENT;
    cfg_data <= frag_floor;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly loads and allocations in matching size ranges, with full-width noise
  function automatic in_req_t random_item();
    in_req_t r;
    r             = '0;
    r.req_type    = ($urandom_range(99) < 30) ? REQ_LOAD : REQ_ALLOC;
    r.entry_index = 4'($urandom_range(15));
    r.entry_start = $urandom;
    case ($urandom_range(9))
      0:       r.entry_size = '0;
      1, 2:    r.entry_size = $urandom;
      3:       r.entry_size = 32'hFFFF_FFFF;
      4, 5:    r.entry_size = $urandom_range(1, 70000);
      default: r.entry_size = $urandom_range(1, 200);
    endcase
    case ($urandom_range(9))
      0:       r.request_size = $urandom_range(1, 32'hFFFF_FFFF);
      1, 2:    r.request_size = $urandom_range(1, 70000);
      3:       r.request_size = 32'hFFFF_FFFF;
      default: r.request_size = $urandom_range(1, 40);
    endcase
    return r;
  endfunction

  initial begin
    logic [15:0] frag_floor;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset policy is first fit with the default fragment floor
    ask(32'd1);                                  // empty table, no fit
    load_slot(4'd0, 32'h0000_1000, 32'd100);
    load_slot(4'd15, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    load_slot(4'd3, 32'hFFFF_FFFF, 32'd0);       // zero size stays unusable
    ask(32'd0);                                  // zero request keeps the size
    ask(32'd200);                                // address wraps past the top
    ask(32'hFFFF_FF37);                          // exact fit empties slot 15
    ask(32'd96);                                 // remainder under the floor
    ask(32'd1);

    // Next fit: pointer stays on the granted slot, then wraps
    program_regs(POL_NEXT, 16'd0);
    load_slot(4'd2, 32'h0000_2000, 32'd10);
    load_slot(4'd9, 32'h0000_9000, 32'd10);
    load_slot(4'd14, 32'h0000_E000, 32'd10);
    ask(32'd3);
    ask(32'd7);
    ask(32'd10);
    ask(32'd4);
    load_slot(4'd1, 32'h0001_0000, 32'd50);
    ask(32'd20);

    // Best fit with equal sizes and the largest floor
    program_regs(POL_BEST, 16'hFFFF);
    load_slot(4'd4, 32'h0000_4000, 32'd30);
    load_slot(4'd6, 32'h0000_6000, 32'd30);
    load_slot(4'd8, 32'h0000_8000, 32'd80);
    ask(32'd25);

    // Worst fit with equal sizes
    program_regs(POL_WORST, 16'd1);
    ask(32'd10);
    load_slot(4'd5, 32'h0000_5000, 32'd70);
    ask(32'd1);
    ask(32'h8000_0000);

    // Random phases across every policy and idling mode
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       frag_floor = 16'd0;
        1:       frag_floor = 16'hFFFF;
        2:       frag_floor = MIN_FRAG_RESET;
        default: frag_floor = (p % 2 == 1) ? 16'($urandom) : 16'($urandom_range(1, 64));
      endcase
      program_regs(policy_e'(p % 4), frag_floor);
      case (p / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 70;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 70;
        end
        default: begin
          send_idle_pct = 22;
          stall_pct    <= 22;
        end
      endcase
      // Fill the block against a long receiver hold
      if (p == 4) hold_kick <= ~hold_kick;
      for (int n = 0; n < PHASE_ITEMS; n++) send(random_item());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("partition_fit_allocator_tb: PASS");
    end else begin
      $display("partition_fit_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/pfa_pkg.sv
sv/pfa_cell.sv
sv/partition_fit_allocator.sv
sv/pfa_checker.sv
test/pfa_checker.sv
test/partition_fit_allocator_tb.sv
